[rtl/hemm_pkg.sv]
package hemm_pkg;

  // Command codes carried in the low bits of the input tdata
  localparam logic [2:0] CMD_ARM_PUMP   = 3'd0;
  localparam logic [2:0] CMD_PUMP_EDGE  = 3'd1;
  localparam logic [2:0] CMD_OPTICAL    = 3'd2;
  localparam logic [2:0] CMD_VALVE_EDGE = 3'd3;
  localparam logic [2:0] CMD_ARM_VALVE  = 3'd4;
  localparam logic [2:0] CMD_TICK       = 3'd5;

  // Motor mode codes
  localparam logic [1:0] MODE_STOP = 2'd0;
  localparam logic [1:0] MODE_FWD  = 2'd1;
  localparam logic [1:0] MODE_REV  = 2'd2;

  // Configuration register indexes
  localparam logic [2:0] REG_PUMP_MODE      = 3'd0;
  localparam logic [2:0] REG_PUMP_TARGET    = 3'd1;
  localparam logic [2:0] REG_OPTICAL_TARGET = 3'd2;
  localparam logic [2:0] REG_VALVE_MODE     = 3'd3;
  localparam logic [2:0] REG_VALVE_TARGET   = 3'd4;
  localparam logic [2:0] REG_PUMP_LIMIT     = 3'd5;
  localparam logic [2:0] REG_VALVE_LIMIT    = 3'd6;
  localparam logic [2:0] REG_SPEED_WINDOW   = 3'd7;

  localparam int unsigned POS_W    = 31;
  localparam int unsigned SUM_W    = 16;
  localparam int unsigned TICK_W   = 32;
  localparam int unsigned TARGET_W = 32;
  localparam int unsigned LIMIT_W  = 16;
  localparam int unsigned IN_W     = 8;
  localparam int unsigned OUT_W    = 136;

  // Per-step controls into one motor channel
  typedef struct packed {
    logic arm;
    logic hall_edge;
    logic aux_hit;
    logic hall_b;
  } motor_ctrl_t;

  typedef struct packed {
    logic direction_fault;
    logic target_reached;
  } motor_flags_t;

  typedef struct packed {
    logic arm;
    logic hall_edge;
    logic tick;
  } speed_ctrl_t;

endpackage

[rtl/hemm_motor.sv]
module hemm_motor
  import hemm_pkg::*;
#(
  parameter int unsigned COUNT_WIDTH = 31,
  parameter int unsigned ERROR_WIDTH = 16,
  parameter bit          WRONG_FWD   = 1'b1
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      go,
  input  motor_ctrl_t               ctrl,
  input  logic [1:0]                mode,
  input  logic [TARGET_W-1:0]       target,
  input  logic [LIMIT_W-1:0]        limit,
  output logic [COUNT_WIDTH-1:0]    count_next,
  output logic [ERROR_WIDTH-1:0]    total_next,
  output motor_flags_t              flags
);

  localparam int unsigned CMP_W = (COUNT_WIDTH > TARGET_W - 1) ? COUNT_WIDTH : TARGET_W - 1;
  localparam int unsigned LIM_W = (ERROR_WIDTH > LIMIT_W) ? ERROR_WIDTH : LIMIT_W;

  logic [COUNT_WIDTH-1:0] count;
  logic [ERROR_WIDTH-1:0] run, run_next;
  logic [ERROR_WIDTH-1:0] total;
  logic                   latched, latched_next;
  logic                   running, wrong, target_met;

  assign running = (mode == MODE_FWD) || (mode == MODE_REV);
  assign wrong   = (mode == MODE_FWD) ? (ctrl.hall_b == WRONG_FWD) : (ctrl.hall_b != WRONG_FWD);

  // -1 disables; any other negative target is met at once
  assign target_met = (target != {TARGET_W{1'b1}}) &&
                      (target[TARGET_W-1] ||
                       (CMP_W'(count_next) >= CMP_W'(target[TARGET_W-2:0])));

  always_comb begin
    count_next   = count;
    run_next     = run;
    total_next   = total;
    latched_next = latched;
    flags        = '0;
    if (ctrl.arm) begin
      count_next   = '0;
      run_next     = '0;
      latched_next = 1'b0;
    end else if (ctrl.hall_edge && running) begin
      if (wrong) begin
        run_next   = (run == {ERROR_WIDTH{1'b1}}) ? run : run + 1'b1;
        total_next = (total == {ERROR_WIDTH{1'b1}}) ? total : total + 1'b1;
      end else begin
        run_next   = '0;
        count_next = count + 1'b1;
      end
      if (!latched && (LIM_W'(run_next) >= LIM_W'(limit))) begin
        latched_next          = 1'b1;
        flags.direction_fault = 1'b1;
      end
      if (!latched_next && target_met) begin
        latched_next         = 1'b1;
        flags.target_reached = 1'b1;
      end
    end else if (ctrl.aux_hit && !latched) begin
      latched_next         = 1'b1;
      flags.target_reached = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count   <= '0;
      run     <= '0;
      total   <= '0;
      latched <= 1'b0;
    end else if (go) begin
      count   <= count_next;
      run     <= run_next;
      total   <= total_next;
      latched <= latched_next;
    end
  end

endmodule

[rtl/hemm_speed.sv]
module hemm_speed
  import hemm_pkg::*;
#(
  parameter int unsigned COUNT_WIDTH = 31
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   go,
  input  speed_ctrl_t            ctrl,
  input  logic [LIMIT_W-1:0]     window,
  input  logic [COUNT_WIDTH-1:0] count_next,
  output logic                   done,
  output logic [TICK_W-1:0]      last_ticks_next
);

  localparam int unsigned CMP_W = (COUNT_WIDTH > LIMIT_W) ? COUNT_WIDTH : LIMIT_W;

  logic                   idle, idle_next;
  logic [COUNT_WIDTH-1:0] start_count, start_count_next;
  logic [TICK_W-1:0]      start_tick, start_tick_next;
  logic [TICK_W-1:0]      tick_now, tick_now_next;
  logic [TICK_W-1:0]      last_ticks;
  logic [COUNT_WIDTH-1:0] delta;

  // an idle window restarts at this edge, so the span is zero
  assign delta = count_next - start_count_next;

  always_comb begin
    idle_next        = idle;
    start_count_next = start_count;
    start_tick_next  = start_tick;
    tick_now_next    = tick_now;
    last_ticks_next  = last_ticks;
    done             = 1'b0;
    if (ctrl.arm) begin
      idle_next = 1'b1;
    end else if (ctrl.tick) begin
      tick_now_next = tick_now + 1'b1;
    end else if (ctrl.hall_edge) begin
      idle_next = 1'b0;
      if (idle) begin
        start_tick_next  = tick_now;
        start_count_next = count_next;
      end
      if (CMP_W'(delta) >= CMP_W'(window)) begin
        idle_next       = 1'b1;
        last_ticks_next = tick_now - start_tick_next;
        done            = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idle        <= 1'b1;
      start_count <= '0;
      start_tick  <= '0;
      tick_now    <= '0;
      last_ticks  <= '0;
    end else if (go) begin
      idle        <= idle_next;
      start_count <= start_count_next;
      start_tick  <= start_tick_next;
      tick_now    <= tick_now_next;
      last_ticks  <= last_ticks_next;
    end
  end

endmodule

[rtl/hall_encoder_move_monitor_unit.sv]
// Hall encoder move monitor for a pump and a valve motor.
// Items pass two registers from input accept to result valid: input register, result register.
// Throughput: 1 item per cycle unless the result stalls; every state update is one compare/increment level.
// A stalled result holds in the output register while the input register still takes one item.
// Reset (rst, synchronous, active high) clears counts, error runs/totals, latches, tick timer
// and loads register defaults: modes stopped, targets -1, limits 3, speed window 100.
module hall_encoder_move_monitor_unit
  import hemm_pkg::*;
#(
  parameter int unsigned COUNT_WIDTH = 31,
  parameter int unsigned ERROR_WIDTH = 16
) (
  input  logic              clk,
  input  logic              rst,
  // input item stream
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [IN_W-1:0]   s_axis_tdata,   // [2:0] command, [3] hall_b_level, [7:4] zero
  // result item stream
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  // [0] pump_direction_fault, [1] pump_target_reached, [2] pump_speed_done,
  // [3] valve_direction_fault, [4] valve_target_reached, [35:5] pump_position,
  // [66:36] valve_position, [98:67] speed_window_ticks, [114:99] pump_error_sum,
  // [130:115] valve_error_sum, [135:131] zero
  output logic [OUT_W-1:0]  m_axis_tdata,
  // configuration write port
  input  logic              cfg_we,
  input  logic [2:0]        cfg_addr,
  input  logic [31:0]       cfg_wdata
);

  localparam int unsigned POS_EXT_W = (COUNT_WIDTH > POS_W) ? COUNT_WIDTH : POS_W;
  localparam int unsigned SUM_EXT_W = (ERROR_WIDTH > SUM_W) ? ERROR_WIDTH : SUM_W;
  localparam int unsigned CMP_W     = (COUNT_WIDTH > TARGET_W - 1) ? COUNT_WIDTH : TARGET_W - 1;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [1:0]          pump_mode, valve_mode;
  logic [TARGET_W-1:0] pump_target, optical_target, valve_target;
  logic [LIMIT_W-1:0]  pump_error_limit, valve_error_limit, speed_window;

  always_ff @(posedge clk) begin
    if (rst) begin
      pump_mode         <= MODE_STOP;
      pump_target       <= '1;
      optical_target    <= '1;
      valve_mode        <= MODE_STOP;
      valve_target      <= '1;
      pump_error_limit  <= LIMIT_W'(3);
      valve_error_limit <= LIMIT_W'(3);
      speed_window      <= LIMIT_W'(100);
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_PUMP_MODE:      pump_mode         <= cfg_wdata[1:0];
        REG_PUMP_TARGET:    pump_target       <= cfg_wdata;
        REG_OPTICAL_TARGET: optical_target    <= cfg_wdata;
        REG_VALVE_MODE:     valve_mode        <= cfg_wdata[1:0];
        REG_VALVE_TARGET:   valve_target      <= cfg_wdata;
        REG_PUMP_LIMIT:     pump_error_limit  <= cfg_wdata[LIMIT_W-1:0];
        REG_VALVE_LIMIT:    valve_error_limit <= cfg_wdata[LIMIT_W-1:0];
        REG_SPEED_WINDOW:   speed_window      <= cfg_wdata[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Input register. It refills in the same cycle its item moves on, so a
  // stalled result costs at most one held item here.
  // ---------------------------------------------------------------------------
  logic       in_valid;
  logic [2:0] in_cmd;
  logic       in_b;
  logic       advance, go;

  assign advance       = !m_axis_tvalid || m_axis_tready;
  assign go            = in_valid && advance;
  assign s_axis_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_cmd <= s_axis_tdata[2:0];
      in_b   <= s_axis_tdata[3];
    end
  end

  // ---------------------------------------------------------------------------
  // Command decode
  // ---------------------------------------------------------------------------
  logic pump_running;
  logic cmd_arm_pump, cmd_pump_edge, cmd_optical, cmd_valve_edge, cmd_arm_valve, cmd_tick;

  assign pump_running = (pump_mode == MODE_FWD) || (pump_mode == MODE_REV);

  always_comb begin
    cmd_arm_pump   = 1'b0;
    cmd_pump_edge  = 1'b0;
    cmd_optical    = 1'b0;
    cmd_valve_edge = 1'b0;
    cmd_arm_valve  = 1'b0;
    cmd_tick       = 1'b0;
    unique case (in_cmd)
      CMD_ARM_PUMP:   cmd_arm_pump   = 1'b1;
      CMD_PUMP_EDGE:  cmd_pump_edge  = 1'b1;
      CMD_OPTICAL:    cmd_optical    = 1'b1;
      CMD_VALVE_EDGE: cmd_valve_edge = 1'b1;
      CMD_ARM_VALVE:  cmd_arm_valve  = 1'b1;
      CMD_TICK:       cmd_tick       = 1'b1;
      default: ;      // unused codes change nothing
    endcase
  end

  // ---------------------------------------------------------------------------
  // Optical pulse counter (pump only); its target hit feeds the pump latch
  // ---------------------------------------------------------------------------
  logic [COUNT_WIDTH-1:0] optical_count, optical_count_next;
  logic                   optical_hit;

  always_comb begin
    optical_count_next = optical_count;
    if (cmd_arm_pump) begin
      optical_count_next = '0;
    end else if (cmd_optical && pump_running) begin
      optical_count_next = optical_count + 1'b1;
    end
  end

  assign optical_hit = cmd_optical && pump_running &&
                       (optical_target != {TARGET_W{1'b1}}) &&
                       (optical_target[TARGET_W-1] ||
                        (CMP_W'(optical_count_next) >= CMP_W'(optical_target[TARGET_W-2:0])));

  always_ff @(posedge clk) begin
    if (rst) begin
      optical_count <= '0;
    end else if (go) begin
      optical_count <= optical_count_next;
    end
  end

  // ---------------------------------------------------------------------------
  // Motor channels. Pump forward expects B low, valve forward expects B high.
  // ---------------------------------------------------------------------------
  motor_ctrl_t            pump_ctrl, valve_ctrl;
  motor_flags_t           pump_flags, valve_flags;
  logic [COUNT_WIDTH-1:0] pump_count_next, valve_count_next;
  logic [ERROR_WIDTH-1:0] pump_total_next, valve_total_next;

  assign pump_ctrl.arm        = cmd_arm_pump;
  assign pump_ctrl.hall_edge  = cmd_pump_edge;
  assign pump_ctrl.aux_hit    = optical_hit;
  assign pump_ctrl.hall_b     = in_b;
  assign valve_ctrl.arm       = cmd_arm_valve;
  assign valve_ctrl.hall_edge = cmd_valve_edge;
  assign valve_ctrl.aux_hit   = 1'b0;
  assign valve_ctrl.hall_b    = in_b;

  hemm_motor #(
    .COUNT_WIDTH (COUNT_WIDTH),
    .ERROR_WIDTH (ERROR_WIDTH),
    .WRONG_FWD   (1'b1)
  ) u_pump (
    .clk        (clk),
    .rst        (rst),
    .go         (go),
    .ctrl       (pump_ctrl),
    .mode       (pump_mode),
    .target     (pump_target),
    .limit      (pump_error_limit),
    .count_next (pump_count_next),
    .total_next (pump_total_next),
    .flags      (pump_flags)
  );

  hemm_motor #(
    .COUNT_WIDTH (COUNT_WIDTH),
    .ERROR_WIDTH (ERROR_WIDTH),
    .WRONG_FWD   (1'b0)
  ) u_valve (
    .clk        (clk),
    .rst        (rst),
    .go         (go),
    .ctrl       (valve_ctrl),
    .mode       (valve_mode),
    .target     (valve_target),
    .limit      (valve_error_limit),
    .count_next (valve_count_next),
    .total_next (valve_total_next),
    .flags      (valve_flags)
  );

  // ---------------------------------------------------------------------------
  // Pump speed window; it keeps running after the move has latched
  // ---------------------------------------------------------------------------
  speed_ctrl_t       speed_ctrl;
  logic              speed_done;
  logic [TICK_W-1:0] speed_ticks_next;

  assign speed_ctrl.arm       = cmd_arm_pump;
  assign speed_ctrl.hall_edge = cmd_pump_edge && pump_running;
  assign speed_ctrl.tick      = cmd_tick;

  hemm_speed #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_speed (
    .clk             (clk),
    .rst             (rst),
    .go              (go),
    .ctrl            (speed_ctrl),
    .window          (speed_window),
    .count_next      (pump_count_next),
    .done            (speed_done),
    .last_ticks_next (speed_ticks_next)
  );

  // ---------------------------------------------------------------------------
  // Result register: positions masked to 31 bits, totals to 16 bits
  // ---------------------------------------------------------------------------
  logic [POS_EXT_W-1:0] pump_pos_ext, valve_pos_ext;
  logic [SUM_EXT_W-1:0] pump_sum_ext, valve_sum_ext;
  logic [OUT_W-1:0]     result;

  assign pump_pos_ext  = POS_EXT_W'(pump_count_next);
  assign valve_pos_ext = POS_EXT_W'(valve_count_next);
  assign pump_sum_ext  = SUM_EXT_W'(pump_total_next);
  assign valve_sum_ext = SUM_EXT_W'(valve_total_next);

  assign result = {5'b0,
                   valve_sum_ext[SUM_W-1:0],
                   pump_sum_ext[SUM_W-1:0],
                   speed_ticks_next,
                   valve_pos_ext[POS_W-1:0],
                   pump_pos_ext[POS_W-1:0],
                   valve_flags.target_reached,
                   valve_flags.direction_fault,
                   speed_done,
                   pump_flags.target_reached,
                   pump_flags.direction_fault};

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (go) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      m_axis_tdata <= result;
    end
  end

endmodule

[rtl/hemm_checker.sv]
module hemm_checker
  import hemm_pkg::*;
(
  input logic             clk,
  input logic             rst,
  input logic             s_axis_tvalid,
  input logic             s_axis_tready,
  input logic             m_axis_tvalid,
  input logic             m_axis_tready,
  input logic [OUT_W-1:0] m_axis_tdata
);

  // result channel empties on reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result valid after reset");

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  // an empty result register never blocks the input side
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output");

  // a move raises at most one brake reason per motor per item
  a_one_flag: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !(m_axis_tdata[0] && m_axis_tdata[1]) &&
                      !(m_axis_tdata[3] && m_axis_tdata[4]))
    else $error("fault and target in one item");

  // an item accepted into an empty block passes the input register, then shows up as a valid result
  a_latency: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && !m_axis_tvalid |=> ##1 m_axis_tvalid)
    else $error("result missing");

endmodule

bind hall_encoder_move_monitor_unit hemm_checker u_hemm_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

[tb/sv/hemm_status_checker.sv]
// Watches both item channels and the register port, keeps its own copy of
// the monitor state and compares every result item with the predicted one.
module hemm_status_checker
  import hemm_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              s_axis_tvalid,
  input  logic              s_axis_tready,
  input  logic [IN_W-1:0]   s_axis_tdata,
  input  logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  input  logic [OUT_W-1:0]  m_axis_tdata,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_addr,
  input  logic [31:0]       cfg_wdata,
  output int                mismatches,
  output int                awaited,
  output int                checked,
  output int                flags_seen
);

  localparam int MAX_REPORTS = 40;

  // Result item layout, MSB first
  typedef struct packed {
    logic [4:0]  pad;
    logic [15:0] valve_err_sum;
    logic [15:0] pump_err_sum;
    logic [31:0] window_ticks;
    logic [30:0] valve_pos;
    logic [30:0] pump_pos;
    logic        valve_target;
    logic        valve_fault;
    logic        pump_speed;
    logic        pump_target;
    logic        pump_fault;
  } move_status_t;

  move_status_t pending_status[$];

  // register copy
  logic [1:0]  pump_mode, valve_mode;
  int          pump_target, optical_target, valve_target;
  logic [15:0] pump_limit, valve_limit, speed_window;

  // monitor state
  logic [30:0] pump_cnt, opt_cnt, valve_cnt, speed_base_cnt;
  logic [15:0] pump_run, pump_tot, valve_run, valve_tot;
  logic        pump_latched, valve_latched, speed_idle;
  logic [31:0] speed_base_tick, tick_now, last_ticks;

  function automatic logic [15:0] sat_up(logic [15:0] v);
    return (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

  // -1 disables; anything else is a signed compare against the count
  function automatic logic target_hit(int tgt, logic [30:0] cnt);
    return (tgt != -1) && (longint'(cnt) >= longint'(tgt));
  endfunction

  // fwd_level: hall B level expected while running forward
  function automatic logic wrong_way(logic [1:0] mode, logic b, logic fwd_level);
    return (mode == MODE_FWD) ? (b != fwd_level) : (b == fwd_level);
  endfunction

  function automatic logic running(logic [1:0] mode);
    return (mode == MODE_FWD) || (mode == MODE_REV);
  endfunction

  task automatic clear_model();
    pump_mode = MODE_STOP;  valve_mode = MODE_STOP;
    pump_target = -1;  optical_target = -1;  valve_target = -1;
    pump_limit = 16'd3;  valve_limit = 16'd3;  speed_window = 16'd100;
    pump_cnt = '0;  opt_cnt = '0;  valve_cnt = '0;  speed_base_cnt = '0;
    pump_run = '0;  pump_tot = '0;  valve_run = '0;  valve_tot = '0;
    pump_latched = 1'b0;  valve_latched = 1'b0;  speed_idle = 1'b1;
    speed_base_tick = '0;  tick_now = '0;  last_ticks = '0;
  endtask

  task automatic write_setting(logic [2:0] addr, logic [31:0] value);
    case (addr)
      REG_PUMP_MODE:      pump_mode = value[1:0];
      REG_PUMP_TARGET:    pump_target = $signed(value);
      REG_OPTICAL_TARGET: optical_target = $signed(value);
      REG_VALVE_MODE:     valve_mode = value[1:0];
      REG_VALVE_TARGET:   valve_target = $signed(value);
      REG_PUMP_LIMIT:     pump_limit = value[15:0];
      REG_VALVE_LIMIT:    valve_limit = value[15:0];
      REG_SPEED_WINDOW:   speed_window = value[15:0];
      default: ;
    endcase
  endtask

  function automatic move_status_t predict_status(logic [2:0] cmd, logic hall_b);
    move_status_t st;
    logic [30:0] span;
    st = '0;
    case (cmd)
      CMD_ARM_PUMP: begin
        // error total survives the re-arm
        pump_cnt = '0;  opt_cnt = '0;  pump_run = '0;
        pump_latched = 1'b0;  speed_idle = 1'b1;
      end
      CMD_PUMP_EDGE: if (running(pump_mode)) begin
        if (wrong_way(pump_mode, hall_b, 1'b0)) begin
          pump_run = sat_up(pump_run);
          pump_tot = sat_up(pump_tot);
        end else begin
          pump_run = '0;
          pump_cnt = pump_cnt + 31'd1;
        end
        // fault wins over target; one flag per move
        if (!pump_latched && pump_run >= pump_limit) begin
          pump_latched = 1'b1;  st.pump_fault = 1'b1;
        end
        if (!pump_latched && target_hit(pump_target, pump_cnt)) begin
          pump_latched = 1'b1;  st.pump_target = 1'b1;
        end
        // speed window keeps going while latched
        if (speed_idle) begin
          speed_idle = 1'b0;
          speed_base_tick = tick_now;
          speed_base_cnt = pump_cnt;
        end
        span = pump_cnt - speed_base_cnt;
        if (span >= speed_window) begin
          speed_idle = 1'b1;
          last_ticks = tick_now - speed_base_tick;
          st.pump_speed = 1'b1;
        end
      end
      CMD_OPTICAL: if (running(pump_mode)) begin
        opt_cnt = opt_cnt + 31'd1;
        if (!pump_latched && target_hit(optical_target, opt_cnt)) begin
          pump_latched = 1'b1;  st.pump_target = 1'b1;
        end
      end
      CMD_VALVE_EDGE: if (running(valve_mode)) begin
        if (wrong_way(valve_mode, hall_b, 1'b1)) begin
          valve_run = sat_up(valve_run);
          valve_tot = sat_up(valve_tot);
        end else begin
          valve_run = '0;
          valve_cnt = valve_cnt + 31'd1;
        end
        if (!valve_latched && valve_run >= valve_limit) begin
          valve_latched = 1'b1;  st.valve_fault = 1'b1;
        end
        if (!valve_latched && target_hit(valve_target, valve_cnt)) begin
          valve_latched = 1'b1;  st.valve_target = 1'b1;
        end
      end
      CMD_ARM_VALVE: begin
        valve_cnt = '0;  valve_run = '0;  valve_latched = 1'b0;
      end
      CMD_TICK: tick_now = tick_now + 32'd1;
      default: ;
    endcase
    st.pump_pos = pump_cnt;
    st.valve_pos = valve_cnt;
    st.window_ticks = last_ticks;
    st.pump_err_sum = pump_tot;
    st.valve_err_sum = valve_tot;
    return st;
  endfunction

  task automatic check_field(string name, longint unsigned want, longint unsigned got);
    if (want != got) begin
      if (mismatches < MAX_REPORTS)
        $display("%0t: %s expected 0x%0h, got 0x%0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  task automatic compare_status(move_status_t want, move_status_t got);
    check_field("pump_direction_fault", want.pump_fault, got.pump_fault);
    check_field("pump_target_reached", want.pump_target, got.pump_target);
    check_field("pump_speed_done", want.pump_speed, got.pump_speed);
    check_field("valve_direction_fault", want.valve_fault, got.valve_fault);
    check_field("valve_target_reached", want.valve_target, got.valve_target);
    check_field("pump_position", want.pump_pos, got.pump_pos);
    check_field("valve_position", want.valve_pos, got.valve_pos);
    check_field("speed_window_ticks", want.window_ticks, got.window_ticks);
    check_field("pump_error_sum", want.pump_err_sum, got.pump_err_sum);
    check_field("valve_error_sum", want.valve_err_sum, got.valve_err_sum);
    check_field("pad bits", want.pad, got.pad);
  endtask

  initial clear_model();

  always @(posedge clk) begin
    move_status_t got;
    if (rst) begin
      clear_model();
      pending_status.delete();
    end else begin
      if (cfg_we)
        write_setting(cfg_addr, cfg_wdata);
      // a result can never belong to an item accepted on the same edge
      if (m_axis_tvalid && m_axis_tready) begin
        got = move_status_t'(m_axis_tdata);
        if ($isunknown(m_axis_tdata)) begin
          $display("%0t: result item has unknown bits: %h", $time, m_axis_tdata);
          mismatches++;
        end else if (pending_status.size() == 0) begin
          $display("%0t: result item with nothing expected: %h", $time, m_axis_tdata);
          mismatches++;
        end else begin
          compare_status(pending_status.pop_front(), got);
          checked++;
          if (got.pump_fault || got.pump_target || got.pump_speed ||
              got.valve_fault || got.valve_target)
            flags_seen++;
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        pending_status.push_back(predict_status(s_axis_tdata[2:0], s_axis_tdata[3]));
    end
    awaited = pending_status.size();
  end

endmodule

[tb/sv/tb_top.sv]
// Stimulus and verdict for the hall encoder move monitor; the result checking is in
// the status checker instantiated beside the block, beside the bound assertions.
module tb_top;
  import hemm_pkg::*;

  // codes the block must ignore
  localparam logic [2:0] CMD_SPARE_6 = 3'd6;
  localparam logic [2:0] CMD_SPARE_7 = 3'd7;
  localparam logic [1:0] MODE_SPARE  = 2'd3;

  localparam int RANDOM_ITEMS = 600;
  // wrong-direction edges per motor in the closing run; longer than its limit
  localparam int RUN_EDGES    = 40;
  // no accept on either side for this long means the block is hung
  localparam int QUIET_LIMIT  = 2000;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [IN_W-1:0]   s_axis_tdata = '0;   // [2:0] command, [3] hall_b_level, [7:4] zero
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  // [0] pump_direction_fault, [1] pump_target_reached, [2] pump_speed_done,
  // [3] valve_direction_fault, [4] valve_target_reached, [35:5] pump_position,
  // [66:36] valve_position, [98:67] speed_window_ticks, [114:99] pump_error_sum,
  // [130:115] valve_error_sum, [135:131] zero
  logic [OUT_W-1:0]  m_axis_tdata;
  logic              cfg_we = 1'b0;
  logic [2:0]        cfg_addr = '0;
  logic [31:0]       cfg_wdata = '0;

  int mismatches, awaited, checked, flags_seen;

  // stimulus bookkeeping
  int          burst_left = 0;
  int          items_sent = 0;
  int          counted = 0;
  int          setups = 0;
  int          wrong_pct = 0;
  logic [1:0]  pump_mode_set = MODE_STOP;
  logic [1:0]  valve_mode_set = MODE_STOP;

  // receiver stall pattern
  int stall_kind = 0;
  int stall_left = 0;
  int quiet_cycles = 0;

  always #2 clk = ~clk;

  hall_encoder_move_monitor_unit i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we        (cfg_we),
    .cfg_addr      (cfg_addr),
    .cfg_wdata     (cfg_wdata)
  );

  hemm_status_checker i_status_check (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we        (cfg_we),
    .cfg_addr      (cfg_addr),
    .cfg_wdata     (cfg_wdata),
    .mismatches    (mismatches),
    .awaited       (awaited),
    .checked       (checked),
    .flags_seen    (flags_seen)
  );

  // Receiver: picks a stall style for a random stretch, then moves on.
  // Styles: always ready, mostly ready, coin flip, and long stalls.
  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_kind = $urandom_range(0, 9);
      stall_left = $urandom_range(8, 80);
    end
    stall_left--;
    case (stall_kind)
      0, 1, 2, 3: m_axis_tready = 1'b1;
      4, 5, 6:    m_axis_tready = ($urandom_range(0, 3) != 0);
      7, 8:       m_axis_tready = 1'($urandom_range(0, 1));
      default:    m_axis_tready = (stall_left % 16 == 0);
    endcase
  end

  // Watchdog: any accept on either channel resets the quiet count.
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb_top: no item moved for %0d cycles, %0d results outstanding",
               QUIET_LIMIT, awaited);
      $display("tb_top: FAIL");
      $finish;
    end
  end

  // Sender: runs in bursts of random length; a new burst may start after a
  // gap with tvalid low. Called and returns at a falling edge.
  task automatic send_item(input logic [2:0] cmd, input logic hall_b);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        s_axis_tvalid = 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    s_axis_tdata = {4'b0000, hall_b, cmd};
    s_axis_tvalid = 1'b1;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    burst_left--;
    items_sent++;
    @(negedge clk);
  endtask

  // Holds the sender off until every predicted result has come back.
  task automatic drain_results();
    s_axis_tvalid = 1'b0;
    burst_left = 0;
    while (awaited != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [2:0] addr, input logic [31:0] value);
    cfg_we = 1'b1;
    cfg_addr = addr;
    cfg_wdata = value;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic set_modes(input logic [1:0] pump_m, input logic [1:0] valve_m);
    write_reg(REG_PUMP_MODE, 32'(pump_m));
    write_reg(REG_VALVE_MODE, 32'(valve_m));
    pump_mode_set = pump_m;
    valve_mode_set = valve_m;
  endtask

  function automatic logic [1:0] pick_mode();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return MODE_STOP;
    if (r == 1) return MODE_SPARE;
    return (r < 6) ? MODE_FWD : MODE_REV;
  endfunction

  function automatic int pick_target();
    case ($urandom_range(0, 5))
      0: return -1;
      1: return -int'($urandom_range(2, 100000));   // below -1: met at once
      2: return 32'h7FFF_FFFF;
      3: return 0;
      default: return $urandom_range(1, 60);
    endcase
  endfunction

  function automatic logic [15:0] pick_limit();
    case ($urandom_range(0, 5))
      0: return 16'd0;
      1: return 16'd1;
      2: return 16'hFFFF;
      default: return 16'($urandom_range(2, 6));
    endcase
  endfunction

  function automatic logic [15:0] pick_window();
    case ($urandom_range(0, 5))
      0: return 16'd0;
      1: return 16'd1;
      2: return 16'hFFFF;
      default: return 16'($urandom_range(2, 15));
    endcase
  endfunction

  task automatic load_random_setup();
    set_modes(pick_mode(), pick_mode());
    write_reg(REG_PUMP_TARGET, 32'(pick_target()));
    write_reg(REG_OPTICAL_TARGET, 32'(pick_target()));
    write_reg(REG_VALVE_TARGET, 32'(pick_target()));
    write_reg(REG_PUMP_LIMIT, 32'(pick_limit()));
    write_reg(REG_VALVE_LIMIT, 32'(pick_limit()));
    write_reg(REG_SPEED_WINDOW, 32'(pick_window()));
    case ($urandom_range(0, 4))
      0: wrong_pct = 0;
      1: wrong_pct = 5;
      2: wrong_pct = 15;
      3: wrong_pct = 40;
      default: wrong_pct = 85;
    endcase
    setups++;
  endtask

  // Hall B level for an edge: the right one for the mode, flipped at the
  // phase's error rate.
  function automatic logic edge_level(logic [1:0] mode, logic fwd_level);
    logic right;
    right = (mode == MODE_REV) ? ~fwd_level : fwd_level;
    return ($urandom_range(0, 99) < wrong_pct) ? ~right : right;
  endfunction

  function automatic logic item_ignored(logic [2:0] cmd);
    case (cmd)
      CMD_PUMP_EDGE, CMD_OPTICAL:
        return !(pump_mode_set == MODE_FWD || pump_mode_set == MODE_REV);
      CMD_VALVE_EDGE:
        return !(valve_mode_set == MODE_FWD || valve_mode_set == MODE_REV);
      CMD_ARM_PUMP, CMD_ARM_VALVE, CMD_TICK:
        return 1'b0;
      default:
        return 1'b1;
    endcase
  endfunction

  // One move: mostly edges in the commanded direction plus ticks and optical
  // pulses, with the odd re-arm, raw command and unused code mixed in.
  task automatic run_random_move(input int goal);
    int done;
    int r;
    logic [2:0] cmd;
    logic b;
    done = 0;
    while (done < goal) begin
      r = $urandom_range(0, 99);
      b = 1'($urandom_range(0, 1));
      if (r < 34) begin
        cmd = CMD_PUMP_EDGE;
        b = edge_level(pump_mode_set, 1'b0);
      end else if (r < 50) begin
        cmd = CMD_VALVE_EDGE;
        b = edge_level(valve_mode_set, 1'b1);
      end else if (r < 72) begin
        cmd = CMD_TICK;
      end else if (r < 80) begin
        cmd = CMD_OPTICAL;
      end else if (r < 85) begin
        cmd = CMD_ARM_PUMP;
      end else if (r < 90) begin
        cmd = CMD_ARM_VALVE;
      end else if (r < 96) begin
        cmd = 3'($urandom_range(0, 7));
      end else begin
        cmd = $urandom_range(0, 1) ? CMD_SPARE_7 : CMD_SPARE_6;
      end
      send_item(cmd, b);
      if (!item_ignored(cmd))
        done++;
    end
    counted += done;
  endtask

  initial begin
    repeat (10) @(negedge clk);
    rst = 1'b0;

    // Reset defaults, both motors stopped: edges and pulses are dropped,
    // unused commands change nothing.
    send_item(CMD_PUMP_EDGE, 1'b1);
    send_item(CMD_OPTICAL, 1'b0);
    send_item(CMD_VALVE_EDGE, 1'b1);
    send_item(CMD_SPARE_6, 1'b1);
    send_item(CMD_SPARE_7, 1'b0);

    // Pump forward, valve backward, short limits and window.
    drain_results();
    set_modes(MODE_FWD, MODE_REV);
    write_reg(REG_PUMP_TARGET, 32'd4);
    write_reg(REG_OPTICAL_TARGET, 32'hFFFF_FFFF);
    write_reg(REG_VALVE_TARGET, 32'd2);
    write_reg(REG_PUMP_LIMIT, 32'd2);
    write_reg(REG_VALVE_LIMIT, 32'd1);
    write_reg(REG_SPEED_WINDOW, 32'd2);
    send_item(CMD_ARM_PUMP, 1'b0);
    send_item(CMD_ARM_VALVE, 1'b1);
    send_item(CMD_PUMP_EDGE, 1'b0);
    send_item(CMD_TICK, 1'b1);
    send_item(CMD_PUMP_EDGE, 1'b0);
    send_item(CMD_PUMP_EDGE, 1'b1);
    send_item(CMD_PUMP_EDGE, 1'b1);    // second wrong edge: direction fault
    send_item(CMD_PUMP_EDGE, 1'b0);    // latched, counts and speed go on
    send_item(CMD_VALVE_EDGE, 1'b0);
    send_item(CMD_VALVE_EDGE, 1'b0);   // valve target
    send_item(CMD_VALVE_EDGE, 1'b1);   // wrong but latched
    send_item(CMD_ARM_VALVE, 1'b0);
    send_item(CMD_VALVE_EDGE, 1'b1);   // limit of one: immediate fault

    // Pump backward, zero limit and window, target below -1, valve in the
    // spare mode code that counts as stopped.
    drain_results();
    set_modes(MODE_REV, MODE_SPARE);
    write_reg(REG_PUMP_TARGET, 32'hFFFF_FFF9);
    write_reg(REG_OPTICAL_TARGET, 32'd1);
    write_reg(REG_PUMP_LIMIT, 32'd0);
    write_reg(REG_SPEED_WINDOW, 32'd0);
    send_item(CMD_ARM_PUMP, 1'b1);
    send_item(CMD_OPTICAL, 1'b1);      // optical target on first pulse
    send_item(CMD_PUMP_EDGE, 1'b1);    // latched; zero window completes
    send_item(CMD_ARM_PUMP, 1'b0);
    send_item(CMD_PUMP_EDGE, 1'b1);    // zero limit faults before target
    send_item(CMD_VALVE_EDGE, 1'b0);
    drain_results();
    write_reg(REG_PUMP_LIMIT, 32'hFFFF);
    send_item(CMD_ARM_PUMP, 1'b1);
    send_item(CMD_PUMP_EDGE, 1'b0);    // negative target met at once

    // Random moves, a fresh register setup per move.
    while (counted < RANDOM_ITEMS) begin
      drain_results();
      load_random_setup();
      send_item(CMD_ARM_PUMP, 1'($urandom_range(0, 1)));
      send_item(CMD_ARM_VALVE, 1'($urandom_range(0, 1)));
      counted += 2;
      run_random_move($urandom_range(30, 90));
    end

    // Long wrong-direction runs on both motors: the fault latches once at the
    // limit, totals keep counting past it, then right edges clear the runs only.
    drain_results();
    set_modes(MODE_FWD, MODE_REV);
    write_reg(REG_PUMP_TARGET, 32'hFFFF_FFFF);
    write_reg(REG_VALVE_TARGET, 32'hFFFF_FFFF);
    write_reg(REG_PUMP_LIMIT, 32'd25);
    write_reg(REG_VALVE_LIMIT, 32'd25);
    send_item(CMD_ARM_PUMP, 1'b0);
    send_item(CMD_ARM_VALVE, 1'b0);
    repeat (RUN_EDGES) begin
      send_item(CMD_PUMP_EDGE, 1'b1);
      send_item(CMD_VALVE_EDGE, 1'b1);
    end
    repeat (3) begin
      send_item(CMD_PUMP_EDGE, 1'b0);
      send_item(CMD_VALVE_EDGE, 1'b0);
    end
    send_item(CMD_ARM_PUMP, 1'b1);
    send_item(CMD_TICK, 1'b0);

    drain_results();
    repeat (8) @(posedge clk);

    $display("tb_top: %0d items sent, %0d results checked, %0d with a flag raised",
             items_sent, checked, flags_seen);
    $display("tb_top: %0d random setups over both motors, closing long wrong-way runs",
             setups);
    if (mismatches == 0 && awaited == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
